FILE: src/ipt_pkg.sv
// Shared definitions for the interval partition table unit.
// Opcodes, status codes, default sizes and the control struct passed along the cell chain.
// No dependencies.
`default_nettype none

package ipt_pkg;

	// Default sizes, handed to the top level as parameter defaults
	localparam int DEF_MAX_ENTRIES  = 64;
	localparam int DEF_VERTEX_WIDTH = 32;

	// Edge count width is fixed by the command format
	localparam int DEG_W = 32;

	// Opcodes
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_SET    = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	// Status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_NOT_FOUND = 2'd3;

	// Control bits of one transaction in flight along the chain
	typedef struct packed {
		logic       valid;   // stage holds a transaction
		logic       wr;      // append or set that passed its checks
		logic       is_set;  // write replaces an existing entry
		logic       lookup;  // vertex lookup
		logic       hit;     // lookup matched in an earlier cell
		logic [1:0] status;  // status decided at the head
	} ctl_t;

endpackage

`default_nettype wire

FILE: src/ipt_head.sv
// Command decoder at the head of the cell chain: keeps the entry count and checks
// append and set against it. Depends on ipt_pkg.
`default_nettype none

module ipt_head import ipt_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int VERTEX_WIDTH = DEF_VERTEX_WIDTH,
	localparam int IDX_W = $clog2(MAX_ENTRIES),
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  logic                    cmd_valid,
	input  logic [1:0]              opcode,
	input  logic [IDX_W-1:0]        entry_index,
	input  logic [VERTEX_WIDTH-1:0] range_start,
	input  logic [VERTEX_WIDTH-1:0] range_end,
	input  logic [DEG_W-1:0]        edge_count,
	input  logic [VERTEX_WIDTH-1:0] vertex_id,
	output ctl_t                    next_ctl,
	output logic [IDX_W-1:0]        next_slot,
	output logic [CNT_W-1:0]        next_count,
	output logic [VERTEX_WIDTH-1:0] next_arg_a,
	output logic [VERTEX_WIDTH-1:0] next_arg_b,
	output logic [DEG_W-1:0]        next_deg
);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_d;
	ctl_t                    ctl_d;
	logic [IDX_W-1:0]        slot_d;
	ctl_t                    ctl_s1;
	logic [IDX_W-1:0]        slot_s1;
	logic [CNT_W-1:0]        count_s1;
	logic [VERTEX_WIDTH-1:0] arg_a_s1;
	logic [VERTEX_WIDTH-1:0] arg_b_s1;
	logic [DEG_W-1:0]        deg_s1;

	// Decode and check against the current entry count
	always_comb begin
		ctl_d       = '0;
		ctl_d.valid = 1'b1;
		ctl_d.status = ST_OK;
		slot_d      = entry_index;
		count_d     = count_q;
		case (opcode)
			OP_APPEND: begin
				slot_d = count_q[IDX_W-1:0];
				if (count_q >= MAX_CNT) begin
					ctl_d.status = ST_FULL;
				end else begin
					ctl_d.wr = 1'b1;
					count_d  = count_q + CNT_W'(1);
				end
			end
			OP_SET: begin
				if (CNT_W'(entry_index) < count_q) begin
					ctl_d.wr     = 1'b1;
					ctl_d.is_set = 1'b1;
				end else begin
					ctl_d.status = ST_BAD_INDEX;
				end
			end
			OP_LOOKUP: begin
				ctl_d.lookup = 1'b1;
			end
			default: begin
				// unused opcode: no change, status ok
			end
		endcase
	end

	// Entry count and stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ctl_s1  <= '0;
		end else if (advance) begin
			ctl_s1 <= cmd_valid ? ctl_d : '0;
			if (cmd_valid) begin
				count_q <= count_d;
			end
		end
	end

	// Payload stage; a lookup carries its vertex in the start field
	always_ff @(posedge clk) begin
		if (advance && cmd_valid) begin
			slot_s1  <= slot_d;
			count_s1 <= count_d;
			arg_a_s1 <= (opcode == OP_LOOKUP) ? vertex_id : range_start;
			arg_b_s1 <= range_end;
			deg_s1   <= edge_count;
		end
	end

	assign next_ctl   = ctl_s1;
	assign next_slot  = slot_s1;
	assign next_count = count_s1;
	assign next_arg_a = arg_a_s1;
	assign next_arg_b = arg_b_s1;
	assign next_deg   = deg_s1;

endmodule

`default_nettype wire

FILE: src/ipt_cell.sv
// One table cell: holds a single interval entry, applies writes aimed at its slot
// and matches lookups as transactions pass by. Depends on ipt_pkg.
`default_nettype none

module ipt_cell import ipt_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int VERTEX_WIDTH = DEF_VERTEX_WIDTH,
	parameter int CELL_IDX = 0,
	localparam int IDX_W = $clog2(MAX_ENTRIES),
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  ctl_t                    prev_ctl,
	input  logic [IDX_W-1:0]        prev_slot,
	input  logic [CNT_W-1:0]        prev_count,
	input  logic [VERTEX_WIDTH-1:0] prev_arg_a,
	input  logic [VERTEX_WIDTH-1:0] prev_arg_b,
	input  logic [DEG_W-1:0]        prev_deg,
	input  logic [DEG_W-1:0]        prev_old_deg,
	input  logic [IDX_W-1:0]        prev_hit_idx,
	output ctl_t                    next_ctl,
	output logic [IDX_W-1:0]        next_slot,
	output logic [CNT_W-1:0]        next_count,
	output logic [VERTEX_WIDTH-1:0] next_arg_a,
	output logic [VERTEX_WIDTH-1:0] next_arg_b,
	output logic [DEG_W-1:0]        next_deg,
	output logic [DEG_W-1:0]        next_old_deg,
	output logic [IDX_W-1:0]        next_hit_idx
);

	localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(CELL_IDX);
	localparam logic [CNT_W-1:0] MY_CNT  = CNT_W'(CELL_IDX);

	// Entry storage, undefined until written
	logic [VERTEX_WIDTH-1:0] start_q;
	logic [VERTEX_WIDTH-1:0] end_q;
	logic [DEG_W-1:0]        deg_q;

	logic                    wr_hit;
	logic                    match;
	ctl_t                    ctl_d;
	ctl_t                    ctl_s1;
	logic [IDX_W-1:0]        slot_s1;
	logic [CNT_W-1:0]        count_s1;
	logic [VERTEX_WIDTH-1:0] arg_a_s1;
	logic [VERTEX_WIDTH-1:0] arg_b_s1;
	logic [DEG_W-1:0]        deg_s1;
	logic [DEG_W-1:0]        old_deg_s1;
	logic [IDX_W-1:0]        hit_idx_s1;

	// Write aimed at this slot; lookup match only on a stored entry
	always_comb begin
		wr_hit = prev_ctl.valid && prev_ctl.wr && (prev_slot == MY_SLOT);
		match  = prev_ctl.valid && prev_ctl.lookup && !prev_ctl.hit &&
			(MY_CNT < prev_count) &&
			(prev_arg_a >= start_q) && (prev_arg_a <= end_q);
		ctl_d = prev_ctl;
		if (match) begin
			ctl_d.hit = 1'b1;
		end
	end

	// Control to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (advance) begin
			ctl_s1 <= ctl_d;
		end
	end

	// Payload to the next cell, entry update
	always_ff @(posedge clk) begin
		if (advance) begin
			slot_s1    <= prev_slot;
			count_s1   <= prev_count;
			arg_a_s1   <= prev_arg_a;
			arg_b_s1   <= prev_arg_b;
			deg_s1     <= prev_deg;
			old_deg_s1 <= (wr_hit && prev_ctl.is_set) ? deg_q : prev_old_deg;
			hit_idx_s1 <= match ? MY_SLOT : prev_hit_idx;
			if (wr_hit) begin
				start_q <= prev_arg_a;
				end_q   <= prev_arg_b;
				deg_q   <= prev_deg;
			end
		end
	end

	assign next_ctl     = ctl_s1;
	assign next_slot    = slot_s1;
	assign next_count   = count_s1;
	assign next_arg_a   = arg_a_s1;
	assign next_arg_b   = arg_b_s1;
	assign next_deg     = deg_s1;
	assign next_old_deg = old_deg_s1;
	assign next_hit_idx = hit_idx_s1;

endmodule

`default_nettype wire

FILE: src/ipt_tail.sv
// End of the cell chain: keeps the running edge total, forms the result and holds it
// in the output register. Also produces the chain advance. Depends on ipt_pkg.
`default_nettype none

module ipt_tail import ipt_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	localparam int IDX_W = $clog2(MAX_ENTRIES),
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1),
	localparam int SUM_W = DEG_W + IDX_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_t             prev_ctl,
	input  logic [CNT_W-1:0] prev_count,
	input  logic [DEG_W-1:0] prev_deg,
	input  logic [DEG_W-1:0] prev_old_deg,
	input  logic [IDX_W-1:0] prev_hit_idx,
	input  logic             rsp_stall,
	output logic             advance,
	output logic             rsp_valid,
	output logic [1:0]       status,
	output logic [IDX_W-1:0] partition_index,
	output logic [SUM_W-1:0] total_edges,
	output logic [CNT_W-1:0] stored_entries
);

	logic             rsp_valid_q;
	logic [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_d;
	logic [1:0]       status_d;
	logic [IDX_W-1:0] part_d;
	logic             load;
	logic [1:0]       status_q;
	logic [IDX_W-1:0] part_q;
	logic [CNT_W-1:0] count_q;

	// Chain moves unless a finished transaction would overrun a stalled result
	assign advance = !(prev_ctl.valid && rsp_valid_q && rsp_stall);
	assign load    = prev_ctl.valid && advance;

	// Running total: a set removes the old count, an append has old count zero
	always_comb begin
		sum_d = sum_q;
		if (prev_ctl.wr) begin
			sum_d = sum_q + SUM_W'(prev_deg) - SUM_W'(prev_old_deg);
		end
		status_d = prev_ctl.status;
		part_d   = '0;
		if (prev_ctl.lookup) begin
			if (prev_ctl.hit) begin
				status_d = ST_OK;
				part_d   = prev_hit_idx;
			end else begin
				status_d = ST_NOT_FOUND;
			end
		end
	end

	// Result valid and edge total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			sum_q       <= '0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
			sum_q       <= sum_d;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (load) begin
			status_q <= status_d;
			part_q   <= part_d;
			count_q  <= prev_count;
		end
	end

	assign rsp_valid       = rsp_valid_q;
	assign status          = status_q;
	assign partition_index = part_q;
	assign total_edges     = sum_q;
	assign stored_entries  = count_q;

endmodule

`default_nettype wire

FILE: src/interval_partition_table_unit.sv
// Interval partition table: a chain of MAX_ENTRIES cells, one per entry, fed by a decoder.
// A command goes from acceptance to result valid via the decoder, each cell and the output register.
// Throughput: one command per cycle; all commands walk the cell chain in order, and the
// chain holds only while a finished result waits behind a stalled output register.
// Reset clears the entry count, edge total and all stage valids; entry storage is not
// cleared, so the unit takes commands right after reset.
`default_nettype none

module interval_partition_table_unit import ipt_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int VERTEX_WIDTH = DEF_VERTEX_WIDTH,
	localparam int IDX_W = $clog2(MAX_ENTRIES),
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1),
	localparam int SUM_W = DEG_W + IDX_W
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cmd_valid,
	output logic                    cmd_stall,
	input  logic [1:0]              opcode,
	input  logic [IDX_W-1:0]        entry_index,
	input  logic [VERTEX_WIDTH-1:0] range_start,
	input  logic [VERTEX_WIDTH-1:0] range_end,
	input  logic [DEG_W-1:0]        edge_count,
	input  logic [VERTEX_WIDTH-1:0] vertex_id,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic [1:0]              status,
	output logic [IDX_W-1:0]        partition_index,
	output logic [SUM_W-1:0]        total_edges,
	output logic [CNT_W-1:0]        stored_entries
);

	logic advance;

	// Links between chain positions; position 0 is the decoder output
	ctl_t                    ctl_c     [0:MAX_ENTRIES];
	logic [IDX_W-1:0]        slot_c    [0:MAX_ENTRIES];
	logic [CNT_W-1:0]        count_c   [0:MAX_ENTRIES];
	logic [VERTEX_WIDTH-1:0] arg_a_c   [0:MAX_ENTRIES];
	logic [VERTEX_WIDTH-1:0] arg_b_c   [0:MAX_ENTRIES];
	logic [DEG_W-1:0]        deg_c     [0:MAX_ENTRIES];
	logic [DEG_W-1:0]        old_deg_c [0:MAX_ENTRIES];
	logic [IDX_W-1:0]        hit_idx_c [0:MAX_ENTRIES];

	assign cmd_stall    = !advance;
	assign old_deg_c[0] = '0;
	assign hit_idx_c[0] = '0;

	// Decoder and entry count
	ipt_head #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.VERTEX_WIDTH(VERTEX_WIDTH)
	) u_head (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.cmd_valid  (cmd_valid),
		.opcode     (opcode),
		.entry_index(entry_index),
		.range_start(range_start),
		.range_end  (range_end),
		.edge_count (edge_count),
		.vertex_id  (vertex_id),
		.next_ctl   (ctl_c[0]),
		.next_slot  (slot_c[0]),
		.next_count (count_c[0]),
		.next_arg_a (arg_a_c[0]),
		.next_arg_b (arg_b_c[0]),
		.next_deg   (deg_c[0])
	);

	// Row of entry cells
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		ipt_cell #(
			.MAX_ENTRIES (MAX_ENTRIES),
			.VERTEX_WIDTH(VERTEX_WIDTH),
			.CELL_IDX    (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.advance     (advance),
			.prev_ctl    (ctl_c[i]),
			.prev_slot   (slot_c[i]),
			.prev_count  (count_c[i]),
			.prev_arg_a  (arg_a_c[i]),
			.prev_arg_b  (arg_b_c[i]),
			.prev_deg    (deg_c[i]),
			.prev_old_deg(old_deg_c[i]),
			.prev_hit_idx(hit_idx_c[i]),
			.next_ctl    (ctl_c[i+1]),
			.next_slot   (slot_c[i+1]),
			.next_count  (count_c[i+1]),
			.next_arg_a  (arg_a_c[i+1]),
			.next_arg_b  (arg_b_c[i+1]),
			.next_deg    (deg_c[i+1]),
			.next_old_deg(old_deg_c[i+1]),
			.next_hit_idx(hit_idx_c[i+1])
		);
	end

	// Edge total and output register
	ipt_tail #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_tail (
		.clk            (clk),
		.arst_n         (arst_n),
		.prev_ctl       (ctl_c[MAX_ENTRIES]),
		.prev_count     (count_c[MAX_ENTRIES]),
		.prev_deg       (deg_c[MAX_ENTRIES]),
		.prev_old_deg   (old_deg_c[MAX_ENTRIES]),
		.prev_hit_idx   (hit_idx_c[MAX_ENTRIES]),
		.rsp_stall      (rsp_stall),
		.advance        (advance),
		.rsp_valid      (rsp_valid),
		.status         (status),
		.partition_index(partition_index),
		.total_edges    (total_edges),
		.stored_entries (stored_entries)
	);

endmodule

`default_nettype wire

FILE: src/ipt_checker.sv
// Port-level checks for the interval partition table unit, bound to the top level.
// Depends on ipt_pkg and interval_partition_table_unit.
`default_nettype none

module ipt_checker import ipt_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	localparam int IDX_W = $clog2(MAX_ENTRIES),
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1),
	localparam int SUM_W = DEG_W + IDX_W
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             rsp_valid,
	input wire logic             rsp_stall,
	input wire logic [1:0]       status,
	input wire logic [IDX_W-1:0] partition_index,
	input wire logic [SUM_W-1:0] total_edges,
	input wire logic [CNT_W-1:0] stored_entries
);

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

	// No result once reset has been seen at a clock edge
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !rsp_valid)
		else $error("result valid during reset");

	// Entry count never exceeds capacity
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> stored_entries <= MAX_CNT)
		else $error("entry count beyond capacity");

	// A full refusal only happens with the table at capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_FULL) |-> stored_entries == MAX_CNT)
		else $error("table full reported below capacity");

	// Any failed transaction reports partition index zero
	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != ST_OK) |-> partition_index == '0)
		else $error("nonzero partition index on failure");

	// A stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(status) &&
			$stable(partition_index) && $stable(total_edges) && $stable(stored_entries)))
		else $error("stalled result changed");

endmodule

bind interval_partition_table_unit ipt_checker #(
	.MAX_ENTRIES(MAX_ENTRIES)
) u_ipt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp_valid),
	.rsp_stall      (rsp_stall),
	.status         (status),
	.partition_index(partition_index),
	.total_edges    (total_edges),
	.stored_entries (stored_entries)
);

`default_nettype wire

FILE: sim/interval_partition_table_unit_tb.sv
// Testbench for interval_partition_table_unit: directed and random table commands,
// with every response checked against a scoreboard that keeps its own copy of the table.
// Depends on ipt_pkg and the unit's RTL.
module interval_partition_table_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ipt_pkg::*;

	localparam int MAX_ENT = DEF_MAX_ENTRIES;
	localparam int VW = DEF_VERTEX_WIDTH;
	localparam int IDX_W = $clog2(MAX_ENT);
	localparam int CNT_W = $clog2(MAX_ENT + 1);
	localparam int SUM_W = DEG_W + IDX_W;
	localparam int LATENCY = MAX_ENT + 2;
	localparam real CLK_PERIOD = 4.0;
	localparam int CYCLE_LIMIT = 200000;
	localparam int END_WAIT = 20000;
	// opcode 3 is not defined by the unit, it must answer ok and change nothing
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]       status;
		logic [IDX_W-1:0] part;
		logic [SUM_W-1:0] total;
		logic [CNT_W-1:0] count;
	} answer_t;

	// Table copy plus the queue of answers still owed by the unit
	class ipt_scoreboard;
		logic [VW-1:0]    range_lo [MAX_ENT];
		logic [VW-1:0]    range_hi [MAX_ENT];
		logic [DEG_W-1:0] degree [MAX_ENT];
		logic [CNT_W-1:0] count;
		logic [SUM_W:0]   edge_sum;
		answer_t          answers[$];
		int               errors;

		function new();
			count = '0;
			edge_sum = '0;
			errors = 0;
		endfunction

		task report(input string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		function int pending();
			return answers.size();
		endfunction

		// Apply one accepted command to the table copy and queue its answer
		function void note_command(input logic [1:0] op, input logic [IDX_W-1:0] idx,
				input logic [VW-1:0] rs, input logic [VW-1:0] re,
				input logic [DEG_W-1:0] ec, input logic [VW-1:0] vid);
			answer_t a;
			int i;
			bit hit;
			a.status = ST_OK;
			a.part = '0;
			hit = 1'b0;
			case (op)
				OP_APPEND: begin
					if (count >= MAX_ENT) begin
						a.status = ST_FULL;
					end else begin
						range_lo[count] = rs;
						range_hi[count] = re;
						degree[count] = ec;
						edge_sum = edge_sum + ec;
						count = count + 1'b1;
					end
				end
				OP_SET: begin
					if (idx >= count) begin
						a.status = ST_BAD_INDEX;
					end else begin
						edge_sum = edge_sum - degree[idx] + ec;
						range_lo[idx] = rs;
						range_hi[idx] = re;
						degree[idx] = ec;
					end
				end
				OP_LOOKUP: begin
					// lowest entry wins; a reversed interval never matches
					for (i = 0; i < count && !hit; i++) begin
						if (vid >= range_lo[i] && vid <= range_hi[i]) begin
							hit = 1'b1;
							a.part = i[IDX_W-1:0];
						end
					end
					if (!hit)
						a.status = ST_NOT_FOUND;
				end
				default: ;
			endcase
			a.total = edge_sum[SUM_W-1:0];
			a.count = count;
			answers.push_back(a);
		endfunction

		task check_response(input logic [1:0] st, input logic [IDX_W-1:0] part,
				input logic [SUM_W-1:0] total, input logic [CNT_W-1:0] cnt);
			answer_t a;
			if (answers.size() == 0) begin
				report("response with no command outstanding");
			end else begin
				a = answers.pop_front();
				if (st !== a.status)
					report($sformatf("status %0d, expected %0d", st, a.status));
				if (part !== a.part)
					report($sformatf("partition_index %0d, expected %0d", part, a.part));
				if (total !== a.total)
					report($sformatf("total_edges %0d, expected %0d", total, a.total));
				if (cnt !== a.count)
					report($sformatf("stored_entries %0d, expected %0d", cnt, a.count));
			end
		endtask

		task finish_check();
			if (answers.size() != 0)
				report($sformatf("%0d responses never arrived", answers.size()));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	logic [1:0] opcode = '0;
	logic [IDX_W-1:0] entry_index = '0;
	logic [VW-1:0] range_start = '0;
	logic [VW-1:0] range_end = '0;
	logic [DEG_W-1:0] edge_count = '0;
	logic [VW-1:0] vertex_id = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic [1:0] status;
	logic [IDX_W-1:0] partition_index;
	logic [SUM_W-1:0] total_edges;
	logic [CNT_W-1:0] stored_entries;

	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	int cycle_count = 0;

	ipt_scoreboard sb = new();

	interval_partition_table_unit #(
		.MAX_ENTRIES(MAX_ENT),
		.VERTEX_WIDTH(VW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.opcode(opcode),
		.entry_index(entry_index),
		.range_start(range_start),
		.range_end(range_end),
		.edge_count(edge_count),
		.vertex_id(vertex_id),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.partition_index(partition_index),
		.total_edges(total_edges),
		.stored_entries(stored_entries)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("interval_partition_table_unit_tb failed");
			$finish;
		end
	end

	// Receiver back-pressure
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
	end

	// Command transactions feed the scoreboard
	always @(posedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall)
			sb.note_command(opcode, entry_index, range_start, range_end, edge_count,
				vertex_id);
	end

	// Response transactions are checked in order
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_response(status, partition_index, total_edges, stored_entries);
	end

	// Drive one command; called and returns at a falling edge
	task send_cmd(input logic [1:0] op, input logic [IDX_W-1:0] idx,
			input logic [VW-1:0] rs, input logic [VW-1:0] re,
			input logic [DEG_W-1:0] ec, input logic [VW-1:0] vid);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		opcode <= op;
		entry_index <= idx;
		range_start <= rs;
		range_end <= re;
		edge_count <= ec;
		vertex_id <= vid;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Hold the sender off until every queued answer has come back
	task wait_drain();
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// Vertex values clustered low, near the top, or anywhere
	function automatic logic [VW-1:0] pick_vertex();
		case ($urandom_range(0, 3))
			0, 1: return $urandom_range(0, 511);
			2: return 32'hFFFF_FE00 + $urandom_range(0, 511);
			default: return $urandom;
		endcase
	endfunction

	task send_random(input int n);
		int r;
		int i;
		int k;
		logic [1:0] op;
		logic [IDX_W-1:0] idx;
		logic [VW-1:0] rs;
		logic [VW-1:0] re;
		logic [VW-1:0] vid;
		logic [DEG_W-1:0] ec;
		for (k = 0; k < n; k++) begin
			// every field gets fresh content, used or not
			idx = IDX_W'($urandom);
			rs = pick_vertex();
			re = rs + $urandom_range(0, 63);
			if ($urandom_range(0, 9) == 0)
				re = rs - $urandom_range(1, 63);
			case ($urandom_range(0, 3))
				0: ec = '1;
				1: ec = $urandom_range(0, 15);
				default: ec = $urandom;
			endcase
			vid = pick_vertex();
			r = $urandom_range(0, 99);
			if (r < 15) begin
				op = OP_APPEND;
			end else if (r < 45) begin
				op = OP_SET;
				if (sb.count != 0 && $urandom_range(0, 4) != 0)
					idx = IDX_W'($urandom_range(0, sb.count - 1));
			end else if (r < 97) begin
				op = OP_LOOKUP;
				// aim most lookups at stored interval boundaries
				if (sb.count != 0 && $urandom_range(0, 2) != 0) begin
					i = $urandom_range(0, sb.count - 1);
					case ($urandom_range(0, 4))
						0: vid = sb.range_lo[i];
						1: vid = sb.range_hi[i];
						2: vid = sb.range_lo[i] - 1'b1;
						3: vid = sb.range_hi[i] + 1'b1;
						default: vid = sb.range_lo[i] + $urandom_range(0, 7);
					endcase
				end
			end else begin
				op = OP_UNUSED;
			end
			send_cmd(op, idx, rs, re, ec, vid);
		end
	endtask

	initial begin
		int waited;
		waited = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty table, extremes, reversed interval, lowest match, bad index
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, '0);
		send_cmd(OP_SET, '0, 32'd1, 32'd2, 32'd3, '0);
		send_cmd(OP_UNUSED, '0, '0, '0, '0, '0);
		send_cmd(OP_APPEND, '0, '0, '1, '1, '0);
		send_cmd(OP_APPEND, '0, 32'd100, 32'd200, '0, '0);
		send_cmd(OP_APPEND, '0, 32'd500, 32'd400, 32'd1, '0);
		send_cmd(OP_APPEND, '0, '1, '1, '1, '0);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, '0);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, 32'd150);
		send_cmd(OP_SET, '0, 32'd10, 32'd20, 32'd5, '0);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, 32'd150);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, 32'd450);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, '1);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, 32'd9);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, 32'd10);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, 32'd20);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, 32'd21);
		send_cmd(OP_SET, 6'd4, 32'd1, 32'd1, 32'd1, '0);
		send_cmd(OP_SET, '1, 32'd1, 32'd1, 32'd1, '0);
		send_cmd(OP_SET, 6'd3, '0, '0, '1, '0);
		send_cmd(OP_LOOKUP, '0, '0, '0, '0, '0);
		send_cmd(OP_UNUSED, '1, '1, '1, '1, '1);
		wait_drain();

		// Random phases: slow receiver, then slow sender, then full rate
		send_idle_pct = 25;
		rsp_stall_pct = 78;
		send_random(670);
		wait_drain();
		send_idle_pct = 78;
		rsp_stall_pct = 25;
		send_random(670);
		wait_drain();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		send_random(660);

		cmd_valid <= 1'b0;
		while (sb.pending() != 0 && waited < END_WAIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (LATENCY + 10) @(posedge clk);
		sb.finish_check();
		if (sb.errors == 0)
			$display("interval_partition_table_unit_tb passed");
		else
			$display("interval_partition_table_unit_tb failed");
		$finish;
	end

endmodule
